[rtl/core/qet_pkg.sv]
`timescale 1ns / 1ps

package qet_pkg;

	// field widths
	localparam int CHAR_W = 8;
	localparam int IDX_W  = 6;
	localparam int CNT_W  = 7;
	localparam int KIND_W = 2;
	localparam int STAT_W = 2;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_CHAR   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_END    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_STATUS = 2'd2;

	// final status codes
	localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STAT_W-1:0] STAT_TOO_MANY  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_NONPRINT  = 2'd2;
	localparam logic [STAT_W-1:0] STAT_UNCLOSED  = 2'd3;

	// token limit
	localparam logic [CNT_W-1:0] TOKEN_LIMIT_CAP = 7'd64;
	localparam logic [CNT_W-1:0] MAX_TOKENS_RST  = 7'd16;

	// result queue depth
	localparam int OUT_DEPTH_DEF = 4;

	// register port
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic REG_MAX_TOKENS = 1'b0;

	// one result item
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [CHAR_W-1:0] char_out;
		logic [IDX_W-1:0]  token_index;
		logic [STAT_W-1:0] status;
		logic [CNT_W-1:0]  token_count;
		logic              last_result;
	} result_t;

endpackage

[rtl/core/qet_core.sv]
`timescale 1ns / 1ps

module qet_core import qet_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  logic [CHAR_W-1:0] char_code,
	input  logic              end_of_string,
	input  logic [CNT_W-1:0]  max_tokens,
	output logic [1:0]        n_res,
	output result_t           res0,
	output result_t           res1
);

	typedef enum logic [1:0] {
		MODE_BETWEEN = 2'd0,
		MODE_WORD    = 2'd1,
		MODE_QUOTED  = 2'd2
	} mode_t;

	localparam logic [CHAR_W-1:0] CH_QUOTE  = 8'h22;
	localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
	localparam logic [CHAR_W-1:0] CH_T      = 8'h74;
	localparam logic [CHAR_W-1:0] CH_B      = 8'h62;
	localparam logic [CHAR_W-1:0] CH_N      = 8'h6E;
	localparam logic [CHAR_W-1:0] CH_R      = 8'h72;
	localparam logic [CHAR_W-1:0] CH_F      = 8'h66;

	mode_t             mode_q, mode_d;
	logic              esc_q, esc_d;
	logic [CNT_W-1:0]  ts_q, ts_d;
	logic              err_q, err_d;

	logic              term, is_space, is_print;
	logic [CNT_W-1:0]  lim, ts_inc;

	function automatic logic [CHAR_W-1:0] translate(input logic [CHAR_W-1:0] c);
		logic [CHAR_W-1:0] r;
		case (c)
			CH_T:    r = 8'h09;
			CH_B:    r = 8'h08;
			CH_N:    r = 8'h0A;
			CH_R:    r = 8'h0D;
			CH_F:    r = 8'h0C;
			default: r = c;
		endcase
		return r;
	endfunction

	function automatic result_t mk_char(input logic [CHAR_W-1:0] c, input logic [CNT_W-1:0] ts);
		result_t r;
		r = '0;
		r.kind = KIND_CHAR;
		r.char_out = c;
		r.token_index = ts[IDX_W-1:0];
		return r;
	endfunction

	function automatic result_t mk_end(input logic [CNT_W-1:0] ts);
		result_t r;
		r = '0;
		r.kind = KIND_END;
		r.token_index = ts[IDX_W-1:0];
		return r;
	endfunction

	function automatic result_t mk_fin(input logic [STAT_W-1:0] st, input logic [CNT_W-1:0] cnt);
		result_t r;
		r = '0;
		r.kind = KIND_STATUS;
		r.status = st;
		r.token_count = cnt;
		r.last_result = 1'b1;
		return r;
	endfunction

	// character classes and clamped limit
	assign term     = end_of_string || (char_code == '0);
	assign is_space = (char_code == 8'h20) || (char_code >= 8'h09 && char_code <= 8'h0D);
	assign is_print = (char_code >= 8'h20) && (char_code <= 8'h7E);
	assign lim      = (max_tokens > TOKEN_LIMIT_CAP) ? TOKEN_LIMIT_CAP : max_tokens;
	assign ts_inc   = ts_q + 1'b1;

	// per-item step
	always_comb begin
		mode_d = mode_q;
		esc_d  = esc_q;
		ts_d   = ts_q;
		err_d  = err_q;
		n_res  = 2'd0;
		res0   = '0;
		res1   = '0;
		if (term) begin
			if (!err_q) begin
				if (mode_q == MODE_QUOTED) begin
					res0  = mk_fin(STAT_UNCLOSED, '0);
					n_res = 2'd1;
				end else if (mode_q == MODE_WORD) begin
					res0  = mk_end(ts_q);
					res1  = mk_fin(STAT_OK, ts_inc);
					n_res = 2'd2;
				end else begin
					res0  = mk_fin(STAT_OK, ts_q);
					n_res = 2'd1;
				end
			end
			mode_d = MODE_BETWEEN;
			esc_d  = 1'b0;
			ts_d   = '0;
			err_d  = 1'b0;
		end else if (!err_q) begin
			if (mode_q != MODE_BETWEEN && esc_q) begin
				// escaped character taken as is, after translation
				esc_d = 1'b0;
				res0  = mk_char(translate(char_code), ts_q);
				n_res = 2'd1;
			end else begin
				unique case (mode_q)
					MODE_BETWEEN: begin
						if (is_space) begin
							n_res = 2'd0;
						end else if (ts_q >= lim) begin
							res0  = mk_fin(STAT_TOO_MANY, '0);
							n_res = 2'd1;
							err_d = 1'b1;
						end else if (char_code == CH_QUOTE) begin
							mode_d = MODE_QUOTED;
						end else if (!is_print) begin
							res0  = mk_fin(STAT_NONPRINT, '0);
							n_res = 2'd1;
							err_d = 1'b1;
						end else begin
							mode_d = MODE_WORD;
							if (char_code == CH_BSLASH) begin
								esc_d = 1'b1;
							end else begin
								res0  = mk_char(char_code, ts_q);
								n_res = 2'd1;
							end
						end
					end
					MODE_WORD: begin
						if (is_space) begin
							res0   = mk_end(ts_q);
							n_res  = 2'd1;
							ts_d   = ts_inc;
							mode_d = MODE_BETWEEN;
						end else if (!is_print) begin
							// word closes, then the error
							res0   = mk_end(ts_q);
							res1   = mk_fin((ts_inc >= lim) ? STAT_TOO_MANY : STAT_NONPRINT, '0);
							n_res  = 2'd2;
							ts_d   = ts_inc;
							mode_d = MODE_BETWEEN;
							err_d  = 1'b1;
						end else if (char_code == CH_BSLASH) begin
							esc_d = 1'b1;
						end else begin
							res0  = mk_char(char_code, ts_q);
							n_res = 2'd1;
						end
					end
					MODE_QUOTED: begin
						if (char_code == CH_QUOTE) begin
							res0   = mk_end(ts_q);
							n_res  = 2'd1;
							ts_d   = ts_inc;
							mode_d = MODE_BETWEEN;
						end else if (!is_print) begin
							res0  = mk_fin(STAT_NONPRINT, '0);
							n_res = 2'd1;
							err_d = 1'b1;
						end else if (char_code == CH_BSLASH) begin
							esc_d = 1'b1;
						end else begin
							res0  = mk_char(char_code, ts_q);
							n_res = 2'd1;
						end
					end
					default: begin
						n_res = 2'd0;
					end
				endcase
			end
		end
	end

	// scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_BETWEEN;
			esc_q  <= 1'b0;
			ts_q   <= '0;
			err_q  <= 1'b0;
		end else if (go) begin
			mode_q <= mode_d;
			esc_q  <= esc_d;
			ts_q   <= ts_d;
			err_q  <= err_d;
		end
	end

`ifndef SYNTHESIS
	a_quiet_after_error: assert property (@(posedge clk) disable iff (!arst_n)
		(go && err_q && !term) |-> (n_res == 2'd0))
		else $error("result produced after error");

	a_second_is_status: assert property (@(posedge clk) disable iff (!arst_n)
		(go && n_res == 2'd2) |-> (res1.kind == KIND_STATUS && res1.last_result))
		else $error("second result of an item is not the final status");

	a_count_capped: assert property (@(posedge clk) disable iff (!arst_n)
		ts_q <= TOKEN_LIMIT_CAP)
		else $error("token count beyond cap");
`endif

endmodule

[rtl/core/qet_out_fifo.sv]
`timescale 1ns / 1ps

module qet_out_fifo import qet_pkg::*; #(
	parameter int DEPTH = OUT_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [1:0] push_n,
	input  result_t    push0,
	input  result_t    push1,
	output logic       room2,
	output logic       out_valid,
	input  logic       out_stall,
	output result_t    head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(DEPTH + 1);

	result_t          mem [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q, wr_nxt;
	logic [CW-1:0]    cnt_q;
	logic             pop;

	function automatic logic [PTR_W-1:0] nxt(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign wr_nxt    = nxt(wr_q);
	assign out_valid = (cnt_q != '0);
	assign pop       = out_valid && !out_stall;
	assign room2     = (cnt_q <= CW'(DEPTH - 2));
	assign head      = mem[rd_q];

	// result storage
	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem[wr_q] <= push0;
		end
		if (push_n == 2'd2) begin
			mem[wr_nxt] <= push1;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push_n == 2'd1) begin
				wr_q <= wr_nxt;
			end else if (push_n == 2'd2) begin
				wr_q <= nxt(wr_nxt);
			end
			if (pop) begin
				rd_q <= nxt(rd_q);
			end
			cnt_q <= cnt_q + CW'(push_n) - CW'(pop);
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push_n != 2'd0) |-> (cnt_q <= CW'(DEPTH - 2)))
		else $error("result queue pushed without room");
`endif

endmodule

[rtl/core/quoted_escape_tokenizer_unit.sv]
`timescale 1ns / 1ps

// Quoted-string tokenizer: takes one character item per cycle while not
// stalled and emits token characters, end-of-token markers and one final
// status per string. A character is registered on entry and is processed
// by the core once the result queue has room; its results are written
// into the result queue, whose head is offered on the output side.
// Sustained rate is one item per cycle while the output side keeps up; an
// item that yields two results (end of token plus status) pushes both into
// the result queue at once. The result queue (OUT_DEPTH entries) must hold
// two free slots for the registered character to be processed, otherwise
// in_stall is raised. max_tokens sits at byte address 0 of the register
// port and resets to 16.
module quoted_escape_tokenizer_unit import qet_pkg::*; #(
	parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// input items
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [CHAR_W-1:0]     char_code,
	input  logic                  end_of_string,
	// result items
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [KIND_W-1:0]     kind,
	output logic [CHAR_W-1:0]     char_out,
	output logic [IDX_W-1:0]      token_index,
	output logic [STAT_W-1:0]     status,
	output logic [CNT_W-1:0]      token_count,
	output logic                  last_result,
	// register port
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	logic              valid_s1;
	logic [CHAR_W-1:0] char_s1;
	logic              eos_s1;
	logic              room2, go;
	logic [1:0]        n_res;
	result_t           res0, res1, head;
	logic [CNT_W-1:0]  max_tokens_q;
	logic              reg_sel;

	// register port
	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == REG_MAX_TOKENS);
	assign prdata  = reg_sel ? APB_DATA_W'(max_tokens_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_tokens_q <= MAX_TOKENS_RST;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			max_tokens_q <= pwdata[CNT_W-1:0];
		end
	end

	// input register
	assign go       = valid_s1 && room2;
	assign in_stall = valid_s1 && !room2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			char_s1 <= char_code;
			eos_s1  <= end_of_string;
		end
	end

	// tokenizer step
	qet_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.go            (go),
		.char_code     (char_s1),
		.end_of_string (eos_s1),
		.max_tokens    (max_tokens_q),
		.n_res         (n_res),
		.res0          (res0),
		.res1          (res1)
	);

	// result queue
	qet_out_fifo #(
		.DEPTH (OUT_DEPTH)
	) u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (go ? n_res : 2'd0),
		.push0     (res0),
		.push1     (res1),
		.room2     (room2),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.head      (head)
	);

	assign kind        = head.kind;
	assign char_out    = head.char_out;
	assign token_index = head.token_index;
	assign status      = head.status;
	assign token_count = head.token_count;
	assign last_result = head.last_result;

`ifndef SYNTHESIS
	a_stall_holds_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> valid_s1)
		else $error("registered item lost while stalled");
`endif

endmodule
